// ===== hw/rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int DIV_BITS = 64;                   // quotient bits, one per divider stage
    localparam logic [32:0] FINE_OFFSET = 33'd128000;
    localparam logic [20:0] P_BASE      = 21'd1048576;
    localparam logic [63:0] P_SCALE     = 64'd3125;
    localparam logic [63:0] VAR1_BIAS   = 64'h0000_8000_0000_0000;  // 1 << 47

    typedef enum logic [1:0] {
        CFG_TEMP_COEFFS  = 2'd0,
        CFG_PRESS_LO     = 2'd1,
        CFG_PRESS_HI     = 2'd2,
        CFG_PRESS_NINE   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_coef;

    // temperature results that ride along with the pressure math
    typedef struct packed {
        logic [31:0] tc;
        logic [31:0] tf;
    } t_side;

endpackage

// ===== hw/rtl/bpc_if.sv =====
// ----------------------------------------------------------------------------
// bpc_if
// Valid/ready channels for raw readings and compensated results.
// ----------------------------------------------------------------------------
interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temp;
    logic        [31:0] pressure_q24_8;
    logic               divide_by_zero;

    modport source (output valid, output temperature_centi, output fine_temp,
                    output pressure_q24_8, output divide_by_zero, input ready);
    modport sink   (input valid, input temperature_centi, input fine_temp,
                    input pressure_q24_8, input divide_by_zero, output ready);
endinterface

// ===== hw/rtl/bpc_temp.sv =====
// ----------------------------------------------------------------------------
// bpc_temp
// Four-stage 32-bit temperature compensation: fine and centi-degree values.
// ----------------------------------------------------------------------------
module bpc_temp import bpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [19:0] i_at,
    input  logic [19:0] i_ap,
    input  t_coef       i_coef,
    output logic        o_vld,
    output t_side       o_side,
    output logic [19:0] o_ap
);

    logic [3:0]  r_vld;
    logic [31:0] r1_x1, r1_dd, r2_v1, r2_m, r3_tf;
    logic [19:0] r1_ap, r2_ap, r3_ap, r4_ap;
    t_side       r4_side;

    logic [31:0] s1_a, s1_d, s1_x1, s1_dd;
    logic signed [31:0] s2_x1s, s2_v1, s2_dds, s2_dsh;
    logic [31:0] s2_m;
    logic signed [31:0] s3_ms, s3_v2, s3_tf;
    logic [31:0] s4_t5;
    logic signed [31:0] s4_t5s, s4_tc;

    function automatic logic signed [31:0] s2_v1_reg_sum(logic [31:0] a, logic [31:0] b);
        return a + b;
    endfunction

    // stage 1: raw products
    assign s1_a  = {15'd0, i_at[19:3]} - {15'd0, i_coef.t1, 1'b0};
    assign s1_x1 = s1_a * {{16{i_coef.t2[15]}}, i_coef.t2};
    assign s1_d  = {16'd0, i_at[19:4]} - {16'd0, i_coef.t1};
    assign s1_dd = s1_d * s1_d;

    // stage 2: var1 and scaled square times T3
    assign s2_x1s = r1_x1;
    assign s2_v1  = s2_x1s >>> 11;
    assign s2_dds = r1_dd;
    assign s2_dsh = s2_dds >>> 12;
    assign s2_m   = s2_dsh * {{16{i_coef.t3[15]}}, i_coef.t3};

    // stage 3: fine temperature
    assign s3_ms = r2_m;
    assign s3_v2 = s3_ms >>> 14;
    assign s3_tf = s2_v1_reg_sum(r2_v1, s3_v2);

    // stage 4: centi-degrees
    assign s4_t5  = r3_tf * 32'd5 + 32'd128;
    assign s4_t5s = s4_t5;
    assign s4_tc  = s4_t5s >>> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x1      <= s1_x1;
            r1_dd      <= s1_dd;
            r1_ap      <= i_ap;
            r2_v1      <= s2_v1;
            r2_m       <= s2_m;
            r2_ap      <= r1_ap;
            r3_tf      <= s3_tf;
            r3_ap      <= r2_ap;
            r4_side.tc <= s4_tc;
            r4_side.tf <= r3_tf;
            r4_ap      <= r3_ap;
        end
    end

    assign o_vld  = r_vld[3];
    assign o_side = r4_side;
    assign o_ap   = r4_ap;

endmodule

// ===== hw/rtl/bpc_pcoef.sv =====
// ----------------------------------------------------------------------------
// bpc_pcoef
// Seven-stage 64-bit pressure prelude: divisor and dividend magnitudes.
// ----------------------------------------------------------------------------
module bpc_pcoef import bpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  t_side       i_side,
    input  logic [19:0] i_ap,
    input  t_coef       i_coef,
    output logic        o_vld,
    output t_side       o_side,
    output logic [63:0] o_nabs,
    output logic [30:0] o_dabs,
    output logic        o_neg,
    output logic        o_dz
);

    logic [6:0] r_vld;
    t_side      r_side [1:7];
    logic [19:0] r_ap [1:4];

    logic        [33:0] r1_ll;
    logic signed [33:0] r1_lh;
    logic signed [31:0] r1_hh;
    logic signed [48:0] r1_w1p5, r1_w1p2, r2_w1p5, r2_w1p2, r3_w1p5, r3_w1p2;
    logic [63:0] r2_sq, r3_m6, r3_m3, r4_w2, r4_v, r5_prod, r5_num0, r6_num, r7_nabs;
    logic [30:0] r6_den, r7_dabs;
    logic        r7_neg, r7_dz;

    logic signed [15:0] c_p2, c_p3, c_p4, c_p5, c_p6;
    assign c_p2 = i_coef.p2;
    assign c_p3 = i_coef.p3;
    assign c_p4 = i_coef.p4;
    assign c_p5 = i_coef.p5;
    assign c_p6 = i_coef.p6;

    // stage 1: var1 = fine - offset, split square into partial products
    logic signed [32:0] s1_w1;
    logic        [16:0] s1_l;
    logic signed [15:0] s1_h;
    logic signed [17:0] s1_ls;
    logic        [33:0] s1_ll;
    logic signed [33:0] s1_lh;
    logic signed [31:0] s1_hh;
    logic signed [48:0] s1_w1p5, s1_w1p2;
    assign s1_w1   = {i_side.tf[31], i_side.tf} - FINE_OFFSET;
    assign s1_l    = s1_w1[16:0];
    assign s1_h    = s1_w1[32:17];
    assign s1_ls   = {1'b0, s1_l};
    assign s1_ll   = 34'(s1_l) * 34'(s1_l);
    assign s1_lh   = 34'(s1_ls) * 34'(s1_h);
    assign s1_hh   = 32'(s1_h) * 32'(s1_h);
    assign s1_w1p5 = 49'(s1_w1) * 49'(c_p5);
    assign s1_w1p2 = 49'(s1_w1) * 49'(c_p2);

    // stage 2: sum the square
    logic signed [63:0] s2_lh64, s2_hh64;
    logic [63:0] s2_sq;
    assign s2_lh64 = 64'(r1_lh);
    assign s2_hh64 = 64'(r1_hh);
    assign s2_sq   = {30'd0, r1_ll} + (s2_lh64 <<< 18) + (s2_hh64 <<< 34);

    // stage 3: square times P6 and P3
    logic signed [63:0] s3_sq;
    logic signed [79:0] s3_m6f, s3_m3f;
    assign s3_sq  = r2_sq;
    assign s3_m6f = 80'(s3_sq) * 80'(c_p6);
    assign s3_m3f = 80'(s3_sq) * 80'(c_p3);

    // stage 4: var2 and var1
    logic signed [63:0] s4_p5e, s4_p2e, s4_p4e, s4_m3, s4_m3sh;
    logic [63:0] s4_w2, s4_v;
    assign s4_p5e  = 64'(r3_w1p5);
    assign s4_p2e  = 64'(r3_w1p2);
    assign s4_p4e  = 64'(c_p4);
    assign s4_m3   = r3_m3;
    assign s4_m3sh = s4_m3 >>> 8;
    assign s4_w2   = r3_m6 + (s4_p5e <<< 17) + (s4_p4e <<< 35);
    assign s4_v    = s4_m3sh + (s4_p2e <<< 12);

    // stage 5: divisor product, dividend base
    logic [63:0] s5_base, s5_prod, s5_num0;
    logic [20:0] s5_pp;
    assign s5_base = r4_v + VAR1_BIAS;
    assign s5_prod = s5_base * {48'd0, i_coef.p1};
    assign s5_pp   = P_BASE - {1'b0, r_ap[4]};
    assign s5_num0 = {12'd0, s5_pp, 31'd0} - r4_w2;

    // stage 6: divisor shift, dividend scale
    logic signed [63:0] s6_ps, s6_den;
    logic [63:0] s6_num;
    assign s6_ps  = r5_prod;
    assign s6_den = s6_ps >>> 33;
    assign s6_num = r5_num0 * P_SCALE;

    // stage 7: magnitudes and sign of the quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[1] <= i_side;
            r_side[2] <= r_side[1];
            r_side[3] <= r_side[2];
            r_side[4] <= r_side[3];
            r_side[5] <= r_side[4];
            r_side[6] <= r_side[5];
            r_side[7] <= r_side[6];
            r_ap[1]   <= i_ap;
            r_ap[2]   <= r_ap[1];
            r_ap[3]   <= r_ap[2];
            r_ap[4]   <= r_ap[3];
            r1_ll     <= s1_ll;
            r1_lh     <= s1_lh;
            r1_hh     <= s1_hh;
            r1_w1p5   <= s1_w1p5;
            r1_w1p2   <= s1_w1p2;
            r2_sq     <= s2_sq;
            r2_w1p5   <= r1_w1p5;
            r2_w1p2   <= r1_w1p2;
            r3_m6     <= s3_m6f[63:0];
            r3_m3     <= s3_m3f[63:0];
            r3_w1p5   <= r2_w1p5;
            r3_w1p2   <= r2_w1p2;
            r4_w2     <= s4_w2;
            r4_v      <= s4_v;
            r5_prod   <= s5_prod;
            r5_num0   <= s5_num0;
            r6_den    <= s6_den[30:0];
            r6_num    <= s6_num;
            r7_neg    <= r6_num[63] ^ r6_den[30];
            r7_nabs   <= r6_num[63] ? (64'd0 - r6_num) : r6_num;
            r7_dabs   <= r6_den[30] ? (31'd0 - r6_den) : r6_den;
            r7_dz     <= (r6_den == 31'd0);
        end
    end

    assign o_vld  = r_vld[6];
    assign o_side = r_side[7];
    assign o_nabs = r7_nabs;
    assign o_dabs = r7_dabs;
    assign o_neg  = r7_neg;
    assign o_dz   = r7_dz;

endmodule

// ===== hw/rtl/bpc_div.sv =====
// ----------------------------------------------------------------------------
// bpc_div
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module bpc_div import bpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [63:0] i_nabs,
    input  logic [30:0] i_dabs,
    input  logic        i_neg,
    input  logic        i_dz,
    input  t_side       i_side,
    output logic        o_vld,
    output logic [63:0] o_q,
    output logic        o_neg,
    output logic        o_dz,
    output t_side       o_side
);

    // n shifts out dividend bits at the top and takes quotient bits at the bottom
    typedef struct packed {
        logic [63:0] n;
        logic [30:0] rem;
        logic [30:0] d;
        logic        neg;
        logic        dz;
        t_side       side;
    } t_dstg;

    logic [DIV_BITS:1] r_vld;
    t_dstg             r_st [1:DIV_BITS];

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
        t_dstg       src;
        logic        src_vld;
        logic [31:0] trial;
        logic        take;
        logic [31:0] diff;
        t_dstg       nxt;

        if (k == 0) begin : g_first
            assign src_vld = i_vld;
            assign src     = '{n: i_nabs, rem: 31'd0, d: i_dabs, neg: i_neg,
                               dz: i_dz, side: i_side};
        end else begin : g_next
            assign src_vld = r_vld[k];
            assign src     = r_st[k];
        end

        assign trial = {src.rem, src.n[63]};
        assign take  = (trial >= {1'b0, src.d});
        assign diff  = trial - {1'b0, src.d};

        always_comb begin
            nxt     = src;
            nxt.n   = {src.n[62:0], take};
            nxt.rem = take ? diff[30:0] : trial[30:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k+1] <= nxt;
            end
        end
    end

    assign o_vld  = r_vld[DIV_BITS];
    assign o_q    = r_st[DIV_BITS].n;
    assign o_neg  = r_st[DIV_BITS].neg;
    assign o_dz   = r_st[DIV_BITS].dz;
    assign o_side = r_st[DIV_BITS].side;

endmodule

// ===== hw/rtl/bpc_ppost.sv =====
// ----------------------------------------------------------------------------
// bpc_ppost
// Five-stage pressure finish: sign fix, P9/P8 terms, Q24.8 result register.
// ----------------------------------------------------------------------------
module bpc_ppost import bpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [63:0] i_q,
    input  logic        i_neg,
    input  logic        i_dz,
    input  t_side       i_side,
    input  t_coef       i_coef,
    output logic        o_vld,
    output logic [31:0] o_pres,
    output logic        o_dz,
    output t_side       o_side
);

    logic [4:0] r_vld;
    t_side      r_side [1:5];
    logic       r_dz [1:5];
    logic [63:0] r1_p, r2_p, r3_p, r4_p, r2_m8, r3_aa, r3_w2, r4_w2, r4_m9;
    logic        [51:0] r2_ll;
    logic signed [51:0] r2_lh;
    logic signed [49:0] r2_hh;
    logic [31:0] r5_pres;

    logic signed [15:0] c_p7, c_p8, c_p9;
    assign c_p7 = i_coef.p7;
    assign c_p8 = i_coef.p8;
    assign c_p9 = i_coef.p9;

    // stage 2: p >> 13 split into partial products, P8 term
    logic signed [63:0] s2_p, s2_a;
    logic        [25:0] s2_al;
    logic signed [24:0] s2_ah;
    logic signed [26:0] s2_als;
    logic        [51:0] s2_ll;
    logic signed [51:0] s2_lh;
    logic signed [49:0] s2_hh;
    logic signed [79:0] s2_m8f;
    assign s2_p   = r1_p;
    assign s2_a   = s2_p >>> 13;
    assign s2_al  = s2_a[25:0];
    assign s2_ah  = s2_a[50:26];
    assign s2_als = {1'b0, s2_al};
    assign s2_ll  = 52'(s2_al) * 52'(s2_al);
    assign s2_lh  = 52'(s2_als) * 52'(s2_ah);
    assign s2_hh  = 50'(s2_ah) * 50'(s2_ah);
    assign s2_m8f = 80'(s2_p) * 80'(c_p8);

    // stage 3: sum the square, shift the P8 term
    logic signed [63:0] s3_lh64, s3_hh64, s3_m8, s3_w2;
    logic [63:0] s3_aa;
    assign s3_lh64 = 64'(r2_lh);
    assign s3_hh64 = 64'(r2_hh);
    assign s3_aa   = {12'd0, r2_ll} + (s3_lh64 <<< 27) + (s3_hh64 <<< 52);
    assign s3_m8   = r2_m8;
    assign s3_w2   = s3_m8 >>> 19;

    // stage 4: square times P9
    logic signed [63:0] s4_aa;
    logic signed [79:0] s4_m9f;
    assign s4_aa  = r3_aa;
    assign s4_m9f = 80'(s4_aa) * 80'(c_p9);

    // stage 5: final sum
    logic signed [63:0] s5_m9, s5_w1, s5_sum, s5_sh, s5_p7e;
    logic [63:0] s5_res;
    assign s5_m9  = r4_m9;
    assign s5_w1  = s5_m9 >>> 25;
    assign s5_sum = r4_p + s5_w1 + r4_w2;
    assign s5_sh  = s5_sum >>> 8;
    assign s5_p7e = 64'(c_p7);
    assign s5_res = s5_sh + (s5_p7e <<< 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[1] <= i_side;
            r_side[2] <= r_side[1];
            r_side[3] <= r_side[2];
            r_side[4] <= r_side[3];
            r_side[5] <= r_side[4];
            r_dz[1]   <= i_dz;
            r_dz[2]   <= r_dz[1];
            r_dz[3]   <= r_dz[2];
            r_dz[4]   <= r_dz[3];
            r_dz[5]   <= r_dz[4];
            r1_p      <= i_neg ? (64'd0 - i_q) : i_q;
            r2_p      <= r1_p;
            r2_ll     <= s2_ll;
            r2_lh     <= s2_lh;
            r2_hh     <= s2_hh;
            r2_m8     <= s2_m8f[63:0];
            r3_p      <= r2_p;
            r3_aa     <= s3_aa;
            r3_w2     <= s3_w2;
            r4_p      <= r3_p;
            r4_w2     <= r3_w2;
            r4_m9     <= s4_m9f[63:0];
            r5_pres   <= r_dz[4] ? 32'd0 : s5_res[31:0];
        end
    end

    assign o_vld  = r_vld[4];
    assign o_pres = r5_pres;
    assign o_dz   = r_dz[5];
    assign o_side = r_side[5];

endmodule

// ===== hw/rtl/baro_temp_pressure_compensate.sv =====
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensate
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// One raw temperature/pressure pair goes in per transaction and one result
// comes out per transaction, in order. The block is a fully pipelined chain
// of 80 register stages: 4 for the 32-bit temperature formula, 7 for the
// 64-bit pressure prelude, 64 for the signed divide (one quotient bit per
// stage) and 5 for the pressure finish, the last being the output register.
// It takes one transaction per cycle and gives one result per cycle, while
// the chain advances. The whole chain advances together: it moves
// whenever the output register is empty or its result is being taken, and
// holds every stage otherwise. Calibration words are written through the
// plain write port and must only change while no transaction is in flight.
// A zero pressure divisor gives pressure 0 with divide_by_zero set; the
// temperature fields are still valid.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensate import bpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    bpc_in_if.sink      i_in,
    bpc_out_if.source   o_out
);

    // calibration registers
    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_lo;
    logic [63:0] r_press_hi;
    logic [15:0] r_press_nine;
    t_coef       coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_press_lo    <= '0;
            r_press_hi    <= '0;
            r_press_nine  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TEMP_COEFFS: r_temp_coeffs <= i_cfg_data[47:0];
                CFG_PRESS_LO:    r_press_lo    <= i_cfg_data;
                CFG_PRESS_HI:    r_press_hi    <= i_cfg_data;
                CFG_PRESS_NINE:  r_press_nine  <= i_cfg_data[15:0];
                default:         r_press_nine  <= r_press_nine;
            endcase
        end
    end

    assign coef.t1 = r_temp_coeffs[15:0];
    assign coef.t2 = r_temp_coeffs[31:16];
    assign coef.t3 = r_temp_coeffs[47:32];
    assign coef.p1 = r_press_lo[15:0];
    assign coef.p2 = r_press_lo[31:16];
    assign coef.p3 = r_press_lo[47:32];
    assign coef.p4 = r_press_lo[63:48];
    assign coef.p5 = r_press_hi[15:0];
    assign coef.p6 = r_press_hi[31:16];
    assign coef.p7 = r_press_hi[47:32];
    assign coef.p8 = r_press_hi[63:48];
    assign coef.p9 = r_press_nine;

    // global advance: every stage moves unless a finished result is held
    logic en;
    logic out_vld;
    assign en         = !out_vld || o_out.ready;
    assign i_in.ready = en;

    logic        t_vld;
    t_side       t_side_o;
    logic [19:0] t_ap;

    bpc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in.valid),
        .i_at    (i_in.raw_temperature),
        .i_ap    (i_in.raw_pressure),
        .i_coef  (coef),
        .o_vld   (t_vld),
        .o_side  (t_side_o),
        .o_ap    (t_ap)
    );

    logic        c_vld;
    t_side       c_side;
    logic [63:0] c_nabs;
    logic [30:0] c_dabs;
    logic        c_neg;
    logic        c_dz;

    bpc_pcoef u_pcoef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (t_vld),
        .i_side  (t_side_o),
        .i_ap    (t_ap),
        .i_coef  (coef),
        .o_vld   (c_vld),
        .o_side  (c_side),
        .o_nabs  (c_nabs),
        .o_dabs  (c_dabs),
        .o_neg   (c_neg),
        .o_dz    (c_dz)
    );

    logic        d_vld;
    logic [63:0] d_q;
    logic        d_neg;
    logic        d_dz;
    t_side       d_side;

    bpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (c_vld),
        .i_nabs  (c_nabs),
        .i_dabs  (c_dabs),
        .i_neg   (c_neg),
        .i_dz    (c_dz),
        .i_side  (c_side),
        .o_vld   (d_vld),
        .o_q     (d_q),
        .o_neg   (d_neg),
        .o_dz    (d_dz),
        .o_side  (d_side)
    );

    logic [31:0] out_pres;
    logic        out_dz;
    t_side       out_side;

    bpc_ppost u_ppost (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (d_vld),
        .i_q     (d_q),
        .i_neg   (d_neg),
        .i_dz    (d_dz),
        .i_side  (d_side),
        .i_coef  (coef),
        .o_vld   (out_vld),
        .o_pres  (out_pres),
        .o_dz    (out_dz),
        .o_side  (out_side)
    );

    assign o_out.valid             = out_vld;
    assign o_out.temperature_centi = out_side.tc;
    assign o_out.fine_temp         = out_side.tf;
    assign o_out.pressure_q24_8    = out_pres;
    assign o_out.divide_by_zero    = out_dz;

    // centi-degree value must match the fine temperature it travels with
    logic [31:0]        chk_t5;
    logic signed [31:0] chk_t5s, chk_tc;
    assign chk_t5  = out_side.tf * 32'd5 + 32'd128;
    assign chk_t5s = chk_t5;
    assign chk_tc  = chk_t5s >>> 8;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_vld && out_dz |-> out_pres == 32'd0)
        else $error("divide_by_zero result with nonzero pressure");

    a_stall_only_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> out_vld && !o_out.ready)
        else $error("input held off without a pending result");

    a_temp_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_vld |-> out_side.tc == chk_tc)
        else $error("temperature fields out of step");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(out_pres) && $stable(out_side))
        else $error("held result changed during stall");

endmodule

// ===== tb/tb_baro_temp_pressure_compensate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_baro_temp_pressure_compensate
// Self-checking bench of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
// Raw reading pairs go through the input channel with random gaps and the
// result channel sees random stalls, but for the all-ones set. A behavioral
// model of the integer temperature and pressure formulas predicts every
// result when its input transaction is accepted, and the monitor checks
// results in order. The run walks through several calibration sets:
// typical factory values, all zero (zero pressure divisor), all ones, the
// most negative and most positive slices, and a few random sets.
// ----------------------------------------------------------------------------
module tb_baro_temp_pressure_compensate import bpc_pkg::*;;

    localparam int PIPE_LATENCY = 80;

    typedef struct {
        logic [19:0] raw_t;
        logic [19:0] raw_p;
    } t_reading;

    typedef struct {
        logic signed [31:0] temp_centi;
        logic signed [31:0] fine_t;
        logic        [31:0] press_q;
        logic               div_zero;
    } t_compensated;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_TEMP_COEFFS;
    logic [63:0] i_cfg_data = '0;

    bpc_in_if  in_ch ();
    bpc_out_if out_ch ();

    baro_temp_pressure_compensate DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // calibration copy used by the predictor
    logic [47:0] temp_cal = '0;
    logic [63:0] press_cal_lo = '0;
    logic [63:0] press_cal_hi = '0;
    logic [15:0] press_cal_nine = '0;

    t_reading     pending_readings[$];
    t_compensated expected_results[$];
    int  fail_count = 0;
    int  result_count = 0;
    int  zero_div_count = 0;
    bit  in_taken = 1'b0;
    bit  quiet_phase = 1'b0;    // no gaps and no stalls while set
    int  send_gap = 0;
    int  take_gap = 0;

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.raw_temperature = '0;
        in_ch.raw_pressure = '0;
        out_ch.ready = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Integer compensation: 32-bit wrap for temperature, 64-bit for pressure.
    function automatic t_compensated compensate_reading(t_reading rd);
        t_compensated res;
        int t1, t2, t3, v1, v2, dt, tf;
        longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint w1, w2, p, num;
        t1 = int'(temp_cal[15:0]);
        t2 = int'(shortint'(temp_cal[31:16]));
        t3 = int'(shortint'(temp_cal[47:32]));
        v1 = ((int'(rd.raw_t >> 3) - (t1 << 1)) * t2) >>> 11;
        dt = int'(rd.raw_t >> 4) - t1;
        v2 = (((dt * dt) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        res.fine_t = tf;
        res.temp_centi = (tf * 5 + 128) >>> 8;

        p1 = longint'(press_cal_lo[15:0]);
        p2 = longint'(shortint'(press_cal_lo[31:16]));
        p3 = longint'(shortint'(press_cal_lo[47:32]));
        p4 = longint'(shortint'(press_cal_lo[63:48]));
        p5 = longint'(shortint'(press_cal_hi[15:0]));
        p6 = longint'(shortint'(press_cal_hi[31:16]));
        p7 = longint'(shortint'(press_cal_hi[47:32]));
        p8 = longint'(shortint'(press_cal_hi[63:48]));
        p9 = longint'(shortint'(press_cal_nine));

        w1 = longint'(tf) - 64'sd128000;
        w2 = w1 * w1 * p6;
        w2 = w2 + ((w1 * p5) << 17);
        w2 = w2 + (p4 << 35);
        w1 = ((w1 * w1 * p3) >>> 8) + ((w1 * p2) << 12);
        w1 = (((64'sd1 <<< 47) + w1) * p1) >>> 33;
        res.press_q = '0;
        res.div_zero = 1'b0;
        if (w1 == 0) begin
            res.div_zero = 1'b1;
        end else begin
            p = 64'sd1048576 - longint'(rd.raw_p);
            num = ((p << 31) - w2) * 64'sd3125;
            // the most negative value over -1 wraps back to itself
            if (w1 == -64'sd1) p = -num;
            else p = num / w1;
            w1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            w2 = (p8 * p) >>> 19;
            p = ((p + w1 + w2) >>> 8) + (p7 << 4);
            res.press_q = p[31:0];
        end
        return res;
    endfunction

    // Driver: present the next reading at the falling edge.
    always @(negedge i_clk) begin
        logic nv;
        nv = in_ch.valid && !in_taken;
        if (!nv) begin
            if (send_gap > 0 && !quiet_phase) begin
                send_gap <= send_gap - 1;
            end else if (pending_readings.size() > 0) begin
                t_reading rd;
                rd = pending_readings.pop_front();
                in_ch.raw_temperature <= rd.raw_t;
                in_ch.raw_pressure <= rd.raw_p;
                nv = 1'b1;
                send_gap <= pick_gap();
            end
        end
        in_ch.valid <= nv;
        if (take_gap > 0 && !quiet_phase) begin
            out_ch.ready <= 1'b0;
            take_gap <= take_gap - 1;
        end else begin
            out_ch.ready <= 1'b1;
            take_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end
    end

    // Monitor: predict on input transactions, check on output transactions.
    always @(posedge i_clk) begin
        t_reading rd;
        t_compensated exp_r;
        in_taken <= in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            rd.raw_t = in_ch.raw_temperature;
            rd.raw_p = in_ch.raw_pressure;
            expected_results.push_back(compensate_reading(rd));
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected");
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (exp_r.div_zero) zero_div_count <= zero_div_count + 1;
                if (out_ch.temperature_centi !== exp_r.temp_centi) begin
                    $error("temperature_centi expected %0d actual %0d",
                           exp_r.temp_centi, out_ch.temperature_centi);
                    fail_count++;
                end
                if (out_ch.fine_temp !== exp_r.fine_t) begin
                    $error("fine_temp expected %0d actual %0d",
                           exp_r.fine_t, out_ch.fine_temp);
                    fail_count++;
                end
                if (out_ch.pressure_q24_8 !== exp_r.press_q) begin
                    $error("pressure_q24_8 expected %0h actual %0h",
                           exp_r.press_q, out_ch.pressure_q24_8);
                    fail_count++;
                end
                if (out_ch.divide_by_zero !== exp_r.div_zero) begin
                    $error("divide_by_zero expected %0b actual %0b",
                           exp_r.div_zero, out_ch.divide_by_zero);
                    fail_count++;
                end
            end
        end
    end

    // Write one calibration register; only called while the pipe is empty.
    task automatic write_cal(t_cfg_idx idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_TEMP_COEFFS: temp_cal = data[47:0];
            CFG_PRESS_LO:    press_cal_lo = data;
            CFG_PRESS_HI:    press_cal_hi = data;
            default:         press_cal_nine = data[15:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_cal_set(logic [47:0] tc, logic [63:0] lo, logic [63:0] hi,
                                logic [15:0] nine);
        write_cal(CFG_TEMP_COEFFS, {16'h0, tc});
        write_cal(CFG_PRESS_LO, lo);
        write_cal(CFG_PRESS_HI, hi);
        write_cal(CFG_PRESS_NINE, {48'h0, nine});
    endtask

    task automatic add_reading(logic [19:0] rt, logic [19:0] rp);
        t_reading rd;
        rd.raw_t = rt;
        rd.raw_p = rp;
        pending_readings.push_back(rd);
    endtask

    // Half realistic readings around room conditions, half anywhere.
    task automatic add_random(int n);
        repeat (n) begin
            if ($urandom_range(0, 1))
                add_reading(20'($urandom_range(380000, 620000)),
                            20'($urandom_range(250000, 600000)));
            else
                add_reading(20'($urandom_range(0, 20'hFFFFF)),
                            20'($urandom_range(0, 20'hFFFFF)));
        end
    endtask

    // Hold until every reading is sent and every result checked, then let
    // the pipeline settle before the next calibration change.
    task automatic drain();
        while (pending_readings.size() > 0 || expected_results.size() > 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // typical factory calibration, directed readings first
        load_cal_set({16'hFC18, 16'd26435, 16'd27504},
                     {16'd2855, 16'd3024, 16'hD645, 16'd36477},
                     {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
        add_reading(20'd519888, 20'd415148);
        add_reading(20'h00000, 20'h00000);
        add_reading(20'hFFFFF, 20'hFFFFF);
        add_reading(20'h00000, 20'hFFFFF);
        add_reading(20'hFFFFF, 20'h00000);
        add_reading(20'hAAAAA, 20'h55555);
        add_reading(20'h55555, 20'hAAAAA);
        add_reading(20'd440000, 20'd300000);
        add_reading(20'd600000, 20'd550000);
        add_random(380);
        drain();

        // zero calibration: pressure divisor is zero for every reading
        load_cal_set('0, '0, '0, '0);
        add_reading(20'd519888, 20'd415148);
        add_reading(20'hFFFFF, 20'h00000);
        add_random(90);
        drain();

        // all ones: T1/P1 at max, every signed slice at -1
        load_cal_set('1, '1, '1, '1);
        quiet_phase = 1'b1;
        add_reading(20'hFFFFF, 20'hFFFFF);
        add_reading(20'h00000, 20'h00000);
        add_random(200);
        drain();
        quiet_phase = 1'b0;

        // most negative signed slices, smallest nonzero unsigned
        load_cal_set({16'h8000, 16'h8000, 16'h0001}, {{3{16'h8000}}, 16'h0001},
                     {4{16'h8000}}, 16'h8000);
        add_reading(20'hFFFFF, 20'h00000);
        add_random(200);
        drain();

        // most positive signed slices
        load_cal_set({16'h7FFF, 16'h7FFF, 16'hFFFF}, {{3{16'h7FFF}}, 16'hFFFF},
                     {4{16'h7FFF}}, 16'h7FFF);
        add_reading(20'h00000, 20'hFFFFF);
        add_random(200);
        drain();

        // random calibration sets
        repeat (5) begin
            load_cal_set(48'({$urandom, $urandom}), {$urandom, $urandom},
                         {$urandom, $urandom}, 16'($urandom));
            add_random(100);
            drain();
        end

        $display("Checked %0d results across 10 calibration sets, %0d with a zero divisor.",
                 result_count, zero_div_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
